[hw/rtl/sui_pkg.sv]
// shared constants and types for the sorted unique insert unit
package sui_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 4;
   localparam int STATUS_W   = 2;
   localparam int TOTAL_W    = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic valid;
      logic load_en;
   } cell_ctl_type;

endpackage

[hw/rtl/sui_cell.sv]
// one table cell: holds an entry, compares it with the key, shifts up on insert
module sui_cell (
   input  logic                                clock,
   input  sui_pkg::cell_ctl_type               ctl,
   input  logic signed [sui_pkg::VALUE_W-1:0]  key,
   input  logic signed [sui_pkg::VALUE_W-1:0]  prev_value,
   input  logic                                prev_lt,
   output logic signed [sui_pkg::VALUE_W-1:0]  value,
   output logic                                lt,
   output logic                                eq,
   output logic                                place
);

   logic signed [sui_pkg::VALUE_W-1:0] value_ff;
   logic signed [sui_pkg::VALUE_W-1:0] value_in;

   always_comb begin
      lt    = ctl.valid && (value_ff < key);
      eq    = ctl.valid && (value_ff == key);
      place = !lt && prev_lt;
      value_in = value_ff;
      if (ctl.load_en && !lt) begin
         value_in = prev_lt ? key : prev_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[hw/rtl/sorted_unique_insert_unit.sv]
// top level: sorted duplicate-free table built as a row of compare-and-shift cells
//
// Each command is accepted when start is high and busy is low. Busy is then
// high for the following cycle while every cell compares its entry with the
// value in parallel and, for an insert that is neither a duplicate nor full,
// the row shifts by one place; the result shows on the rsp_ ports with
// rsp_strobe high for one cycle after that. A new command may be started in
// the same cycle the result is shown, but start is ignored while busy is high.
// The receiver cannot stall. Status is done, duplicate (checked before full)
// or full; a clear empties the table. Position and entry_total wrap to their
// field widths when CAPACITY exceeds them.
module sorted_unique_insert_unit #(
   parameter int CAPACITY = sui_pkg::CAPACITY_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_cmd,
   input  logic signed [sui_pkg::VALUE_W-1:0]     req_value,
   output logic                                   rsp_strobe,
   output logic [sui_pkg::POSITION_W-1:0]         rsp_position,
   output logic [sui_pkg::STATUS_W-1:0]           rsp_status,
   output logic [sui_pkg::TOTAL_W-1:0]            rsp_entry_total
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                               pend_ff, pend_in;
   logic                               cmd_ff, cmd_in;
   logic signed [sui_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic                               strobe_ff, strobe_in;
   logic [sui_pkg::POSITION_W-1:0]     position_ff, position_in;
   logic [sui_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [sui_pkg::TOTAL_W-1:0]        total_ff, total_in;

   logic signed [sui_pkg::VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]                cell_lt;
   logic [CAPACITY-1:0]                cell_eq;
   logic [CAPACITY-1:0]                cell_place;
   logic                               dup;
   logic                               full;
   logic                               insert_go;
   logic [IDX_W-1:0]                   pos;

   assign dup       = |cell_eq;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign insert_go = pend_ff && (cmd_ff == sui_pkg::CMD_INSERT) && !dup && !full;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sui_pkg::cell_ctl_type ctl;
      logic signed [sui_pkg::VALUE_W-1:0] prev_value;
      logic prev_lt;

      assign ctl.valid   = (CNT_W'(i) < count_ff);
      assign ctl.load_en = insert_go;

      if (i == 0) begin : g_head
         assign prev_value = value_ff;
         assign prev_lt    = 1'b1;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_lt    = cell_lt[i-1];
      end

      sui_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key        (value_ff),
         .prev_value (prev_value),
         .prev_lt    (prev_lt),
         .value      (cell_value[i]),
         .lt         (cell_lt[i]),
         .eq         (cell_eq[i]),
         .place      (cell_place[i])
      );
   end

   // insertion point is the single cell where the less-than run ends
   always_comb begin
      pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_place[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
   end

   always_comb begin
      pend_in  = pend_ff;
      cmd_in   = cmd_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (pend_ff) begin
         pend_in = 1'b0;
      end else if (start) begin
         pend_in  = 1'b1;
         cmd_in   = req_cmd;
         value_in = req_value;
      end
      if (pend_ff && (cmd_ff == sui_pkg::CMD_CLEAR)) begin
         count_in = '0;
      end else if (insert_go) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      strobe_in   = pend_ff;
      position_in = '0;
      status_in   = sui_pkg::STATUS_DONE;
      total_in    = sui_pkg::TOTAL_W'(count_in);
      if (cmd_ff == sui_pkg::CMD_INSERT) begin
         priority if (dup) begin
            status_in = sui_pkg::STATUS_DUP;
         end else if (full) begin
            status_in = sui_pkg::STATUS_FULL;
         end else begin
            position_in = sui_pkg::POSITION_W'(pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      if (pend_ff) begin
         position_ff <= position_in;
         status_ff   <= status_in;
         total_ff    <= total_in;
      end
   end

   assign busy            = pend_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_position    = position_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_total = total_ff;

`ifndef NO_ASSERTIONS
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy) else $error("busy held longer than one cycle");

   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not enter update");

   a_strobe_follows_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("result without a pending item");

   a_rejected_position_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != sui_pkg::STATUS_DONE)) |-> (rsp_position == '0))
      else $error("rejected item reports a nonzero position");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
`endif

endmodule
